// ----- hdl/ldfe_pkg.sv -----
// Package for the LED dashboard frame encoder.
// Holds frame constants, glyph codes and the byte-encoding functions.
// No dependencies.
`default_nettype none

package ldfe_pkg;

  localparam int unsigned FRAME_BYTES = 6;
  localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] FRAME_LAST = IDX_W'(FRAME_BYTES - 1);

  localparam logic [3:0] BAR_FULL = 4'd8;
  localparam logic [6:0] SHOW_MAX = 7'd99;

  // Letter glyphs for the out-of-range display
  localparam logic [7:0] GLYPH_L = 8'h2C;
  localparam logic [7:0] GLYPH_O = 8'hEE;
  localparam logic [7:0] GLYPH_H = 8'hBA;
  localparam logic [7:0] GLYPH_I = 8'h82;

  typedef logic [7:0] byte_t;

  // Seven-segment code for one decimal digit
  function automatic byte_t seg_code(input logic [3:0] digit);
    byte_t code;
    case (digit)
      4'd0:    code = 8'hEE;
      4'd1:    code = 8'h82;
      4'd2:    code = 8'hDC;
      4'd3:    code = 8'hD6;
      4'd4:    code = 8'hB2;
      4'd5:    code = 8'h76;
      4'd6:    code = 8'h7E;
      4'd7:    code = 8'hC2;
      4'd8:    code = 8'hFE;
      4'd9:    code = 8'hF6;
      default: code = 8'hEE;
    endcase
    return code;
  endfunction

  // Bar lit from bit 0 upward, level saturated at a full bar
  function automatic byte_t fill_from_low(input logic [3:0] level);
    logic [3:0] n;
    logic [8:0] ones;
    n    = (level > BAR_FULL) ? BAR_FULL : level;
    ones = (9'd1 << n) - 9'd1;
    return ones[7:0];
  endfunction

  // Bar lit from bit 7 downward, level saturated at a full bar
  function automatic byte_t fill_from_high(input logic [3:0] level);
    logic [3:0]  n;
    logic [15:0] mask;
    n    = (level > BAR_FULL) ? BAR_FULL : level;
    mask = 16'hFF00 >> n;
    return mask[7:0];
  endfunction

  function automatic byte_t swap_halves(input byte_t b);
    return {b[3:0], b[7:4]};
  endfunction

endpackage

`default_nettype wire

// ----- hdl/led_dashboard_frame_encoder.sv -----
// LED dashboard frame encoder, top level.
// Depends on ldfe_pkg for constants and encoding functions.
//
// Each accepted frame yields six driver bytes, one per output transaction: top lamps,
// left bar, right bar, bottom lamps, right digit (nibbles swapped), left digit. The
// sixth byte carries out_frame_end for the latch pulse. A frame held in the input
// register is loaded into the output shift register on the same edge the previous
// frame's last byte is taken, so frames stream without gaps. When the block is empty,
// an accepted frame passes through the input register before it is loaded into the
// output shift register. in_stall is high while the input register holds a frame
// not yet moved to the output side.
`default_nettype none

module led_dashboard_frame_encoder
  import ldfe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [3:0]        in_left_level,
  input  wire logic [3:0]        in_right_level,
  input  wire logic [7:0]        in_top_lamps,
  input  wire logic [7:0]        in_bottom_lamps,
  input  wire logic signed [7:0] in_shown_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_driver_byte,
  output logic                   out_frame_end
);

  // Input register
  logic              pend_vld_r, pend_vld_nxt;
  logic [3:0]        left_r, right_r;
  logic [7:0]        top_r, bottom_r;
  logic signed [7:0] value_r;

  // Output shift register
  byte_t             frame_r [FRAME_BYTES];
  byte_t             enc     [FRAME_BYTES];
  logic              busy_r, busy_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;

  logic              in_take, out_take, last_byte, load;
  logic              is_neg, is_hi;
  logic [6:0]        mag;
  logic [14:0]       prod;
  logic [3:0]        tens;
  logic [3:0]        units;
  byte_t             left_seg, right_seg;

  // Handshake
  assign in_stall  = pend_vld_r;
  assign in_take   = in_valid & ~pend_vld_r;
  assign out_take  = busy_r & ~out_stall;
  assign last_byte = (cnt_r == FRAME_LAST);
  assign load      = pend_vld_r & (~busy_r | (out_take & last_byte));

  // Split the number into digits: multiply by reciprocal, exact below 100
  assign is_neg = value_r[7];
  assign mag    = value_r[6:0];
  assign is_hi  = ~is_neg & (mag > SHOW_MAX);
  assign prod   = 15'(mag) * 15'd205;
  assign tens   = prod[14:11];
  assign units  = 4'(mag - 7'(tens) * 7'd10);

  always_comb begin
    if (is_neg) begin
      left_seg  = GLYPH_L;
      right_seg = GLYPH_O;
    end else if (is_hi) begin
      left_seg  = GLYPH_H;
      right_seg = GLYPH_I;
    end else begin
      left_seg  = seg_code(tens);
      right_seg = seg_code(units);
    end
  end

  // Assemble the frame in shift-out order
  always_comb begin
    enc[0] = top_r;
    enc[1] = fill_from_low(left_r);
    enc[2] = fill_from_high(right_r);
    enc[3] = bottom_r;
    enc[4] = swap_halves(right_seg);
    enc[5] = left_seg;
  end

  // Control next state
  always_comb begin
    pend_vld_nxt = (pend_vld_r & ~load) | in_take;
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (out_take) begin
      busy_nxt = ~last_byte;
      cnt_nxt  = last_byte ? '0 : cnt_r + 1'b1;
    end else begin
      busy_nxt = busy_r;
      cnt_nxt  = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      busy_r     <= 1'b0;
      cnt_r      <= '0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      busy_r     <= busy_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (in_take) begin
      left_r   <= in_left_level;
      right_r  <= in_right_level;
      top_r    <= in_top_lamps;
      bottom_r <= in_bottom_lamps;
      value_r  <= in_shown_value;
    end
  end

  // Load a new frame or advance by one byte
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < FRAME_BYTES; i++) frame_r[i] <= enc[i];
    end else if (out_take) begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) frame_r[i] <= frame_r[i+1];
    end
  end

  assign out_valid       = busy_r;
  assign out_driver_byte = frame_r[0];
  assign out_frame_end   = last_byte;

endmodule

`default_nettype wire

// ----- hdl/ldfe_checker.sv -----
// Port-level checker for the LED dashboard frame encoder, with its bind.
// Depends on ldfe_pkg for the frame length.
`default_nettype none

module ldfe_checker
  import ldfe_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic [3:0]        in_left_level,
  input wire logic [3:0]        in_right_level,
  input wire logic [7:0]        in_top_lamps,
  input wire logic [7:0]        in_bottom_lamps,
  input wire logic signed [7:0] in_shown_value,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [7:0]        out_driver_byte,
  input wire logic              out_frame_end
);

  logic             in_acc, out_acc;
  logic [IDX_W-1:0] pos_r;
  logic [2:0]       open_r;

  assign in_acc  = in_valid & ~in_stall;
  assign out_acc = out_valid & ~out_stall;

  // Track byte position within a frame and frames in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      open_r <= '0;
    end else begin
      if (out_acc) pos_r <= (pos_r == FRAME_LAST) ? '0 : pos_r + 1'b1;
      open_r <= open_r + 3'(in_acc) - 3'(out_acc & out_frame_end);
    end
  end

  // Frame end marks exactly the sixth byte
  a_frame_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_end == (pos_r == FRAME_LAST)))
    else $error("frame_end on wrong byte position");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_driver_byte)
      && $stable(out_frame_end))
    else $error("stalled result changed");

  // An accepted frame is followed by valid output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##2 out_valid)
    else $error("no output after accepted frame");

  // At most two frames in flight
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    open_r <= 3'd2)
    else $error("too many frames in flight");

endmodule

bind led_dashboard_frame_encoder ldfe_checker u_ldfe_checker (.*);

`default_nettype wire
